// File: src/lcdseq_pkg.sv
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Types, constants and the control store for the character LCD 4-bit
// write sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

    localparam int ADDR_W = 5;

    localparam logic [ADDR_W-1:0] ENTRY_INIT = 5'd0;
    localparam logic [ADDR_W-1:0] ENTRY_BYTE = 5'd21;

    localparam logic [15:0] HOLD_STROBE  = 16'd1;
    localparam logic [15:0] HOLD_NIBBLE  = 16'd100;
    localparam logic [15:0] HOLD_POWERUP = 16'd50000;
    localparam logic [15:0] HOLD_WAKE    = 16'd5000;
    localparam logic [15:0] HOLD_CLEAR   = 16'd2000;

    localparam logic [7:0] CLEAR_BYTE = 8'h01;

    typedef enum logic [2:0] {
        CMD_INIT   = 3'd0,
        CMD_WRITE  = 3'd1,
        CMD_DATA   = 3'd2,
        CMD_SETPOS = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        NIB_CONST,
        NIB_HI,
        NIB_LO
    } nib_src_t;

    // Sequencing: advance, finish, or advance only for a request with a tail step.
    typedef enum logic [1:0] {
        OP_NEXT,
        OP_DONE,
        OP_TAIL
    } seq_op_t;

    typedef struct packed {
        nib_src_t    nib_src;
        logic [3:0]  nib_const;
        logic        rs_from_reg;
        logic        en;
        logic [15:0] hold;
        seq_op_t     op;
    } uword_t;

    typedef struct packed {
        logic        valid;
        nib_src_t    nib_src;
        logic [3:0]  nib_const;
        logic        rs_from_reg;
        logic        en;
        logic [15:0] hold;
        logic        last;
    } step_ctl_t;

    function automatic uword_t mk(input nib_src_t s, input logic [3:0] c, input logic rs,
                                  input logic en, input logic [15:0] h, input seq_op_t op);
        uword_t w;
        w.nib_src     = s;
        w.nib_const   = c;
        w.rs_from_reg = rs;
        w.en          = en;
        w.hold        = h;
        w.op          = op;
        return w;
    endfunction

    function automatic uword_t ucode(input logic [ADDR_W-1:0] a);
        uword_t w;
        case (a)
            // initialise
            5'd0:  w = mk(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_POWERUP, OP_NEXT);
            5'd1:  w = mk(NIB_CONST, 4'h3, 1'b0, 1'b1, HOLD_STROBE,  OP_NEXT);
            5'd2:  w = mk(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_WAKE,    OP_NEXT);
            5'd3:  w = mk(NIB_CONST, 4'h3, 1'b0, 1'b1, HOLD_STROBE,  OP_NEXT);
            5'd4:  w = mk(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_WAKE,    OP_NEXT);
            5'd5:  w = mk(NIB_CONST, 4'h3, 1'b0, 1'b1, HOLD_STROBE,  OP_NEXT);
            5'd6:  w = mk(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_WAKE,    OP_NEXT);
            5'd7:  w = mk(NIB_CONST, 4'h2, 1'b0, 1'b1, HOLD_STROBE,  OP_NEXT);
            5'd8:  w = mk(NIB_CONST, 4'h2, 1'b0, 1'b0, HOLD_NIBBLE,  OP_NEXT);
            5'd9:  w = mk(NIB_CONST, 4'h2, 1'b0, 1'b1, HOLD_STROBE,  OP_NEXT);
            5'd10: w = mk(NIB_CONST, 4'h2, 1'b0, 1'b0, HOLD_NIBBLE,  OP_NEXT);
            5'd11: w = mk(NIB_CONST, 4'h8, 1'b0, 1'b1, HOLD_STROBE,  OP_NEXT);
            5'd12: w = mk(NIB_CONST, 4'h8, 1'b0, 1'b0, HOLD_NIBBLE,  OP_NEXT);
            5'd13: w = mk(NIB_CONST, 4'h0, 1'b0, 1'b1, HOLD_STROBE,  OP_NEXT);
            5'd14: w = mk(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_NIBBLE,  OP_NEXT);
            5'd15: w = mk(NIB_CONST, 4'hc, 1'b0, 1'b1, HOLD_STROBE,  OP_NEXT);
            5'd16: w = mk(NIB_CONST, 4'hc, 1'b0, 1'b0, HOLD_NIBBLE,  OP_NEXT);
            5'd17: w = mk(NIB_CONST, 4'h0, 1'b0, 1'b1, HOLD_STROBE,  OP_NEXT);
            5'd18: w = mk(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_NIBBLE,  OP_NEXT);
            5'd19: w = mk(NIB_CONST, 4'h6, 1'b0, 1'b1, HOLD_STROBE,  OP_NEXT);
            5'd20: w = mk(NIB_CONST, 4'h6, 1'b0, 1'b0, HOLD_NIBBLE,  OP_DONE);
            // byte write from the byte register
            5'd21: w = mk(NIB_HI,    4'h0, 1'b1, 1'b1, HOLD_STROBE,  OP_NEXT);
            5'd22: w = mk(NIB_HI,    4'h0, 1'b1, 1'b0, HOLD_NIBBLE,  OP_NEXT);
            5'd23: w = mk(NIB_LO,    4'h0, 1'b1, 1'b1, HOLD_STROBE,  OP_NEXT);
            5'd24: w = mk(NIB_LO,    4'h0, 1'b1, 1'b0, HOLD_NIBBLE,  OP_TAIL);
            // clear wait
            5'd25: w = mk(NIB_CONST, 4'h1, 1'b0, 1'b0, HOLD_CLEAR,   OP_DONE);
            default: w = mk(NIB_CONST, 4'h0, 1'b0, 1'b0, 16'd0,      OP_DONE);
        endcase
        return w;
    endfunction

endpackage

// File: src/lcdseq_ctrl.sv
// ----------------------------------------------------------------------------
// lcdseq_ctrl
// Step counter and control store: dispatches a request to its entry point
// and walks the program one step per cycle.
// ----------------------------------------------------------------------------
module lcdseq_ctrl
    import lcdseq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] cmd,
    output logic       busy,
    output logic       load,
    output step_ctl_t  step
);

    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic              busy_reg, busy_next;
    logic              tail_reg, tail_next;
    logic              cmd_known;
    uword_t            uw;

    assign uw        = ucode(pc_reg);
    assign cmd_known = (cmd == CMD_INIT) || (cmd == CMD_WRITE) || (cmd == CMD_DATA) ||
                       (cmd == CMD_SETPOS) || (cmd == CMD_CLEAR);
    assign load      = start && !busy_reg && cmd_known;
    assign busy      = busy_reg;

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        tail_next = tail_reg;
        if (load)
        begin
            busy_next = 1'b1;
            pc_next   = (cmd == CMD_INIT) ? ENTRY_INIT : ENTRY_BYTE;
            tail_next = (cmd == CMD_CLEAR);
        end
        else if (busy_reg)
        begin
            case (uw.op)
                OP_NEXT: pc_next = pc_reg + 5'd1;
                OP_DONE: busy_next = 1'b0;
                OP_TAIL:
                begin
                    if (tail_reg)
                        pc_next = pc_reg + 5'd1;
                    else
                        busy_next = 1'b0;
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        step.valid       = busy_reg;
        step.nib_src     = uw.nib_src;
        step.nib_const   = uw.nib_const;
        step.rs_from_reg = uw.rs_from_reg;
        step.en          = uw.en;
        step.hold        = uw.hold;
        step.last        = (uw.op == OP_DONE) || ((uw.op == OP_TAIL) && !tail_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= ENTRY_INIT;
            busy_reg <= 1'b0;
            tail_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
            tail_reg <= tail_next;
        end
    end

endmodule

// File: src/lcdseq_dp.sv
// ----------------------------------------------------------------------------
// lcdseq_dp
// Datapath: byte and register-select latch, nibble select and the
// registered pin-step outputs.
// ----------------------------------------------------------------------------
module lcdseq_dp
    import lcdseq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [2:0]  cmd,
    input  logic [7:0]  byte_value,
    input  logic        row,
    input  logic [5:0]  column,
    input  step_ctl_t   step,
    output logic        strobe,
    output logic [3:0]  nibble,
    output logic        reg_select,
    output logic        enable,
    output logic [15:0] hold_us,
    output logic        last
);

    logic [7:0]  byte_reg, byte_next;
    logic        rs_reg;
    logic        strobe_reg;
    logic [3:0]  nibble_reg, nibble_next;
    logic        reg_select_reg;
    logic        enable_reg;
    logic [15:0] hold_us_reg;
    logic        last_reg;

    always_comb
    begin
        case (cmd)
            CMD_SETPOS: byte_next = {1'b1, row, column};
            CMD_CLEAR:  byte_next = CLEAR_BYTE;
            default:    byte_next = byte_value;
        endcase
    end

    always_comb
    begin
        case (step.nib_src)
            NIB_HI:  nibble_next = byte_reg[7:4];
            NIB_LO:  nibble_next = byte_reg[3:0];
            default: nibble_next = step.nib_const;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            rs_reg   <= (cmd == CMD_DATA);
        end
        nibble_reg     <= nibble_next;
        reg_select_reg <= step.rs_from_reg & rs_reg;
        enable_reg     <= step.en;
        hold_us_reg    <= step.hold;
        last_reg       <= step.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= step.valid;
    end

    assign strobe     = strobe_reg;
    assign nibble     = nibble_reg;
    assign reg_select = reg_select_reg;
    assign enable     = enable_reg;
    assign hold_us    = hold_us_reg;
    assign last       = last_reg;

endmodule

// File: src/char_lcd_nibble_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Turns LCD requests into pin steps for a character LCD on a 4-bit bus.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its pin steps then
// appear one per clock, each for one cycle with strobe high. The first step
// shows once the request has passed through the step counter and then the
// datapath output registers, and the final step has last set. The output
// cannot be stalled, so the receiver must take every step as it comes.
// Command, data and set-position requests give 4 steps, clear gives 5 and
// initialise 21. Busy is high while they are walked, one control store step
// per cycle. It drops as the final step is shown, so a new request may be
// taken in that cycle. Unused command codes are not taken and give no steps.
// hold_us is a time for downstream pacing logic to honor; this block does
// not wait it out.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer
    import lcdseq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [7:0]  byte_value,
    input  logic        row,
    input  logic [5:0]  column,
    output logic        strobe,
    output logic [3:0]  nibble,
    output logic        reg_select,
    output logic        enable,
    output logic [15:0] hold_us,
    output logic        last
);

    logic      load;
    step_ctl_t step;

    lcdseq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .load  (load),
        .step  (step)
    );

    lcdseq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .cmd        (cmd),
        .byte_value (byte_value),
        .row        (row),
        .column     (column),
        .step       (step),
        .strobe     (strobe),
        .nibble     (nibble),
        .reg_select (reg_select),
        .enable     (enable),
        .hold_us    (hold_us),
        .last       (last)
    );

endmodule

// File: src/lcdseq_checker.sv
// ----------------------------------------------------------------------------
// lcdseq_checker
// Port-level checks for the character LCD write sequencer, bound to the
// top level.
// ----------------------------------------------------------------------------
module lcdseq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  cmd,
    input logic [7:0]  byte_value,
    input logic        row,
    input logic [5:0]  column,
    input logic        strobe,
    input logic [3:0]  nibble,
    input logic        reg_select,
    input logic        enable,
    input logic [15:0] hold_us,
    input logic        last
);

    a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("step shown without a request in progress");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !busy)
        else $error("still busy on final step");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy)
        else $error("request ended without a final step");

    a_strobe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && enable) |-> (hold_us == 16'd1))
        else $error("enable-high step with wrong hold time");

endmodule

bind char_lcd_nibble_write_sequencer lcdseq_checker u_lcdseq_checker (.*);
